### design/cdajd_pkg.sv
package cdajd_pkg;

    localparam int NUM_W    = 57;
    localparam int JD_W     = 23;
    localparam int NUMOUT_W = 40;
    localparam int DEN_W    = 18;

    typedef enum logic [4:0] {
        S_IDLE,
        S_JD1,
        S_JD2,
        S_SPLIT,
        S_GINIT,
        S_GTEST,
        S_GWAIT,
        S_QN,
        S_QNWAIT,
        S_QD,
        S_QDWAIT,
        S_T2A,
        S_T2B,
        S_T3A,
        S_T3B,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_JD1,
        OP_JD2,
        OP_DATE,
        OP_T1,
        OP_T2A,
        OP_T2B,
        OP_T3A,
        OP_T3B,
        OP_GINIT,
        OP_GDIV,
        OP_GSTEP,
        OP_QN,
        OP_QNTAKE,
        OP_QD,
        OP_QDTAKE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic a_zero;
        logic div_done;
        logic out_busy;
    } status_t;

    // floor(30.6001 * (m + 1)) for the shifted month
    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] t;
        begin
            case (m)
                4'd3:    t = 9'd122;
                4'd4:    t = 9'd153;
                4'd5:    t = 9'd183;
                4'd6:    t = 9'd214;
                4'd7:    t = 9'd244;
                4'd8:    t = 9'd275;
                4'd9:    t = 9'd306;
                4'd10:   t = 9'd336;
                4'd11:   t = 9'd367;
                4'd12:   t = 9'd397;
                4'd13:   t = 9'd428;
                4'd14:   t = 9'd459;
                4'd15:   t = 9'd489;
                default: t = 9'd0;
            endcase
            return t;
        end
    endfunction

endpackage

### design/cdajd_in_if.sv
interface cdajd_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source(output valid, mode, year, month, day, hour, minute, second, input ready);
    modport sink(input valid, mode, year, month, day, hour, minute, second, output ready);
endinterface

### design/cdajd_out_if.sv
interface cdajd_out_if;
    logic        valid;
    logic        ready;
    logic [22:0] julian_day;
    logic [39:0] ajd_numerator;
    logic [17:0] ajd_denominator;

    modport source(output valid, julian_day, ajd_numerator, ajd_denominator, input ready);
    modport sink(input valid, julian_day, ajd_numerator, ajd_denominator, output ready);
endinterface

### design/cdajd_div.sv
module cdajd_div #(
    parameter int WIDTH = cdajd_pkg::NUM_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvsr_reg, dvsr_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(WIDTH - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/cdajd_datapath.sv
module cdajd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cdajd_pkg::cmd_t     cmd,
    output cdajd_pkg::status_t  status,
    input  logic                mode,
    input  logic [13:0]         year,
    input  logic [3:0]          month,
    input  logic [4:0]          day,
    input  logic [4:0]          hour,
    input  logic [5:0]          minute,
    input  logic [5:0]          second,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [22:0]         julian_day,
    output logic [39:0]         ajd_numerator,
    output logic [17:0]         ajd_denominator
);

    localparam int W = cdajd_pkg::NUM_W;

    logic        mode_reg, mode_next;
    logic [13:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [25:0] yprod_reg, yprod_next;
    logic [7:0]  cent_reg, cent_next;
    logic [8:0]  mterm_reg, mterm_next;
    logic [22:0] jd_reg, jd_next;
    logic [W-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] tmp_reg, tmp_next;
    logic [W-1:0] tmp2_reg, tmp2_next;
    logic        out_valid_reg, out_valid_next;
    logic [22:0] res_jd_reg, res_jd_next;
    logic [39:0] res_num_reg, res_num_next;
    logic [17:0] res_den_reg, res_den_next;

    logic         early;
    logic [13:0]  yadj;
    logic [14:0]  yplus;
    logic [3:0]   madj;
    logic [27:0]  cent_prod;
    logic [25:0]  jd_sum;
    logic [54:0]  jd_den_prod;
    logic         div_start;
    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    logic         div_done;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    cdajd_div #(
        .WIDTH(W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // january and february belong to the previous year
    assign early     = (month_reg <= 4'd2);
    assign yadj      = year_reg - 14'(early);
    assign yplus     = 15'(year_reg) + 15'd4716 - 15'(early);
    assign madj      = early ? month_reg + 4'd12 : month_reg;
    assign cent_prod = 28'(yadj) * 28'd5243;
    assign jd_sum    = 26'(yprod_reg >> 2) + 26'(mterm_reg) + 26'(day_reg) + 26'd2
                     + 26'(cent_reg >> 2) - 26'(cent_reg) - 26'd1524;
    assign jd_den_prod = jd_reg * den_reg[31:0];

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = b_reg;
        div_divisor  = a_reg;
        case (cmd.op)
            cdajd_pkg::OP_GDIV:
            begin
                div_start = 1'b1;
            end
            cdajd_pkg::OP_QN:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = b_reg;
            end
            cdajd_pkg::OP_QD:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                div_divisor  = b_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        yprod_next  = yprod_reg;
        cent_next   = cent_reg;
        mterm_next  = mterm_reg;
        jd_next     = jd_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        tmp_next    = tmp_reg;
        tmp2_next   = tmp2_reg;
        res_jd_next  = res_jd_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.op)
            cdajd_pkg::OP_LOAD:
            begin
                mode_next   = mode;
                year_next   = year;
                month_next  = month;
                day_next    = day;
                hour_next   = hour;
                minute_next = minute;
                second_next = second;
            end
            cdajd_pkg::OP_JD1:
            begin
                yprod_next = 26'(yplus) * 26'd1461;
                cent_next  = (early && year_reg == 14'd0) ? 8'd0 : cent_prod[26:19];
                mterm_next = cdajd_pkg::month_term(madj);
            end
            cdajd_pkg::OP_JD2:
            begin
                jd_next = jd_sum[22:0];
            end
            cdajd_pkg::OP_DATE:
            begin
                num_next = W'({jd_reg, 1'b0}) - W'(1);
                den_next = W'(2);
            end
            cdajd_pkg::OP_T1:
            begin
                num_next = W'(hour_reg) * W'(1440) + W'(minute_reg) * W'(24);
                den_next = W'(34560);
            end
            cdajd_pkg::OP_T2A:
            begin
                tmp_next  = W'(34'(num_reg[15:0]) * 34'd86400);
                tmp2_next = W'(22'(second_reg) * 22'(den_reg[15:0]));
                den_next  = W'(34'(den_reg[15:0]) * 34'd86400);
            end
            cdajd_pkg::OP_T2B:
            begin
                num_next = tmp_reg + tmp2_reg;
            end
            cdajd_pkg::OP_T3A:
            begin
                tmp_next = W'(jd_den_prod);
            end
            cdajd_pkg::OP_T3B:
            begin
                num_next = {tmp_reg[W-2:0], 1'b0} + {num_reg[W-2:0], 1'b0} - den_reg;
                den_next = {den_reg[W-2:0], 1'b0};
            end
            cdajd_pkg::OP_GINIT:
            begin
                a_next = num_reg;
                b_next = den_reg;
            end
            cdajd_pkg::OP_GSTEP:
            begin
                a_next = div_rem;
                b_next = a_reg;
            end
            cdajd_pkg::OP_QNTAKE:
            begin
                num_next = div_quo;
            end
            cdajd_pkg::OP_QDTAKE:
            begin
                den_next = div_quo;
            end
            cdajd_pkg::OP_OUT:
            begin
                res_jd_next    = jd_reg;
                res_num_next   = num_reg[39:0];
                res_den_next   = den_reg[17:0];
                out_valid_next = 1'b1;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        second_reg  <= second_next;
        yprod_reg   <= yprod_next;
        cent_reg    <= cent_next;
        mterm_reg   <= mterm_next;
        jd_reg      <= jd_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        tmp_reg     <= tmp_next;
        tmp2_reg    <= tmp2_next;
        res_jd_reg  <= res_jd_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
    end

    assign status.mode     = mode_reg;
    assign status.a_zero   = (a_reg == '0);
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign julian_day      = res_jd_reg;
    assign ajd_numerator   = res_num_reg;
    assign ajd_denominator = res_den_reg;

endmodule

### design/cdajd_ctrl.sv
module cdajd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cdajd_pkg::status_t  status,
    output cdajd_pkg::cmd_t     cmd
);

    cdajd_pkg::state_t state_reg, state_next;
    logic [1:0]        stage_reg, stage_next;

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        case (state_reg)
            cdajd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cdajd_pkg::S_JD1;
                end
            end
            cdajd_pkg::S_JD1:
            begin
                state_next = cdajd_pkg::S_JD2;
            end
            cdajd_pkg::S_JD2:
            begin
                state_next = cdajd_pkg::S_SPLIT;
            end
            cdajd_pkg::S_SPLIT:
            begin
                stage_next = 2'd0;
                state_next = status.mode ? cdajd_pkg::S_GINIT : cdajd_pkg::S_OUT;
            end
            cdajd_pkg::S_GINIT:
            begin
                state_next = cdajd_pkg::S_GTEST;
            end
            cdajd_pkg::S_GTEST:
            begin
                state_next = status.a_zero ? cdajd_pkg::S_QN : cdajd_pkg::S_GWAIT;
            end
            cdajd_pkg::S_GWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = cdajd_pkg::S_GTEST;
                end
            end
            cdajd_pkg::S_QN:
            begin
                state_next = cdajd_pkg::S_QNWAIT;
            end
            cdajd_pkg::S_QNWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = cdajd_pkg::S_QD;
                end
            end
            cdajd_pkg::S_QD:
            begin
                state_next = cdajd_pkg::S_QDWAIT;
            end
            cdajd_pkg::S_QDWAIT:
            begin
                if (status.div_done)
                begin
                    case (stage_reg)
                        2'd0:    state_next = cdajd_pkg::S_T2A;
                        2'd1:    state_next = cdajd_pkg::S_T3A;
                        default: state_next = cdajd_pkg::S_OUT;
                    endcase
                end
            end
            cdajd_pkg::S_T2A:
            begin
                state_next = cdajd_pkg::S_T2B;
            end
            cdajd_pkg::S_T2B:
            begin
                stage_next = 2'd1;
                state_next = cdajd_pkg::S_GINIT;
            end
            cdajd_pkg::S_T3A:
            begin
                state_next = cdajd_pkg::S_T3B;
            end
            cdajd_pkg::S_T3B:
            begin
                stage_next = 2'd2;
                state_next = cdajd_pkg::S_GINIT;
            end
            cdajd_pkg::S_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = cdajd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdajd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = cdajd_pkg::OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            cdajd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = cdajd_pkg::OP_LOAD;
                end
            end
            cdajd_pkg::S_JD1:    cmd.op = cdajd_pkg::OP_JD1;
            cdajd_pkg::S_JD2:    cmd.op = cdajd_pkg::OP_JD2;
            cdajd_pkg::S_SPLIT:  cmd.op = status.mode ? cdajd_pkg::OP_T1 : cdajd_pkg::OP_DATE;
            cdajd_pkg::S_GINIT:  cmd.op = cdajd_pkg::OP_GINIT;
            cdajd_pkg::S_GTEST:
            begin
                if (!status.a_zero)
                begin
                    cmd.op = cdajd_pkg::OP_GDIV;
                end
            end
            cdajd_pkg::S_GWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = cdajd_pkg::OP_GSTEP;
                end
            end
            cdajd_pkg::S_QN:     cmd.op = cdajd_pkg::OP_QN;
            cdajd_pkg::S_QNWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = cdajd_pkg::OP_QNTAKE;
                end
            end
            cdajd_pkg::S_QD:     cmd.op = cdajd_pkg::OP_QD;
            cdajd_pkg::S_QDWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = cdajd_pkg::OP_QDTAKE;
                end
            end
            cdajd_pkg::S_T2A:    cmd.op = cdajd_pkg::OP_T2A;
            cdajd_pkg::S_T2B:    cmd.op = cdajd_pkg::OP_T2B;
            cdajd_pkg::S_T3A:    cmd.op = cdajd_pkg::OP_T3A;
            cdajd_pkg::S_T3B:    cmd.op = cdajd_pkg::OP_T3B;
            cdajd_pkg::S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op = cdajd_pkg::OP_OUT;
                end
            end
            default:
            begin
                cmd.op = cdajd_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdajd_pkg::S_IDLE;
            stage_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
        end
    end

endmodule

### design/civil_datetime_to_ajd_fraction.sv
// date mode: the states IDLE (load), JD1, JD2, SPLIT and OUT lead from transaction to result register
// datetime mode: the euclid steps run on the shared 57-bit
// restoring divider that serves every modulo and every division by the gcd
// throughput: one transaction at a time; the next is taken once the result is registered
// reset: asynchronous active-low rst_n clears the controller, divider and output valid
module civil_datetime_to_ajd_fraction (
    input  logic        clk,
    input  logic        rst_n,
    cdajd_in_if.sink    item,
    cdajd_out_if.source result
);

    cdajd_pkg::cmd_t    cmd;
    cdajd_pkg::status_t status;
    logic               ready;

    cdajd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(item.valid),
        .in_ready(ready),
        .status  (status),
        .cmd     (cmd)
    );

    cdajd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (item.mode),
        .year           (item.year),
        .month          (item.month),
        .day            (item.day),
        .hour           (item.hour),
        .minute         (item.minute),
        .second         (item.second),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .julian_day     (result.julian_day),
        .ajd_numerator  (result.ajd_numerator),
        .ajd_denominator(result.ajd_denominator)
    );

    assign item.ready = ready;

endmodule

### verif/cdajd_checker.sv
module cdajd_checker (
    input  logic        clk,
    input  logic        rst_n,
    cdajd_in_if         item,
    cdajd_out_if        result,
    output int          fail_count,
    output int          pending
);
    typedef struct {
        logic [22:0] jd;
        logic [39:0] num;
        logic [17:0] den;
    } ajd_t;

    ajd_t expected_q[$];
    int   mismatch_count;
    int   datetime_seen;

    function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (a != 0)
        begin
            t = a;
            a = b % a;
            b = t;
        end
        return b;
    endfunction

    function automatic logic [63:0] day_number(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy);
        longint y;
        longint m;
        longint cent;
        longint total;
        y = yr;
        m = mo;
        if (m <= 2)
        begin
            y = y - 1;
            m = m + 12;
        end
        cent = (y < 0) ? 0 : y / 100;
        total = ((y + 4716) * 1461) / 4 + ((m + 1) * 306001) / 10000 + dy
                + 2 - cent + cent / 4 - 1524;
        return total;
    endfunction

    function automatic ajd_t convert(logic md, logic [13:0] yr, logic [3:0] mo,
                                     logic [4:0] dy, logic [4:0] hr,
                                     logic [5:0] mi, logic [5:0] se);
        ajd_t r;
        logic [63:0] jd;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] g;
        jd = day_number(yr, mo, dy);
        if (!md)
        begin
            num = jd * 2 - 1;
            den = 2;
        end
        else
        begin
            num = hr * 1440 + mi * 24;
            den = 24 * 1440;
            g = euclid(num, den);
            if (g != 0) begin num = num / g; den = den / g; end
            num = num * 86400 + se * den;
            den = den * 86400;
            g = euclid(num, den);
            if (g != 0) begin num = num / g; den = den / g; end
            num = (jd * den + num) * 2 - den;
            den = den * 2;
            g = euclid(num, den);
            if (g != 0) begin num = num / g; den = den / g; end
        end
        r.jd = jd[22:0];
        r.num = num[39:0];
        r.den = den[17:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ajd_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            mismatch_count = 0;
            datetime_seen = 0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                expected_q.push_back(convert(item.mode, item.year, item.month, item.day,
                                             item.hour, item.minute, item.second));
                if (item.mode)
                    datetime_seen++;
            end
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (mismatch_count++ < 10)
                        $display("unexpected result jd=%0d num=%0d den=%0d",
                                 result.julian_day, result.ajd_numerator,
                                 result.ajd_denominator);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.jd !== result.julian_day || e.num !== result.ajd_numerator
                        || e.den !== result.ajd_denominator)
                    begin
                        fail_count <= fail_count + 1;
                        if (mismatch_count++ < 10)
                            $display("mismatch exp jd=%0d num=%0d den=%0d got jd=%0d num=%0d den=%0d",
                                     e.jd, e.num, e.den, result.julian_day,
                                     result.ajd_numerator, result.ajd_denominator);
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

### verif/civil_datetime_to_ajd_fraction_tb.sv
module civil_datetime_to_ajd_fraction_tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   sent;

    cdajd_in_if  item ();
    cdajd_out_if result ();

    civil_datetime_to_ajd_fraction u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    cdajd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink side stalls
    initial
    begin
        int n;
        result.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            n = gap_length();
            if (n > 0)
            begin
                result.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            result.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_date(logic md, logic [13:0] yr, logic [3:0] mo, logic [4:0] dy,
                             logic [4:0] hr, logic [5:0] mi, logic [5:0] se);
        int gap;
        item.valid  <= 1'b1;
        item.mode   <= md;
        item.year   <= yr;
        item.month  <= mo;
        item.day    <= dy;
        item.hour   <= hr;
        item.minute <= mi;
        item.second <= se;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sent++;
        if ($urandom_range(0, 3) != 0)
        begin
            gap = gap_length();
            if (gap > 0)
            begin
                item.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_random();
        logic [4:0] hr;
        logic [5:0] mi;
        logic [5:0] se;
        hr = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
        mi = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        se = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        send_date($urandom_range(0, 3) != 0, 14'($urandom_range(0, 9999)),
                  ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12)),
                  5'($urandom), hr, mi, se);
    endtask

    initial
    begin
        item.valid  = 1'b0;
        item.mode   = 1'b0;
        item.year   = '0;
        item.month  = 4'd1;
        item.day    = 5'd1;
        item.hour   = '0;
        item.minute = '0;
        item.second = '0;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_date(1'b0, 14'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
        send_date(1'b1, 14'd2000, 4'd1, 5'd1, 5'd12, 6'd0, 6'd0);
        send_date(1'b0, 14'd0, 4'd1, 5'd1, 5'd31, 6'd63, 6'd63);
        send_date(1'b1, 14'd0, 4'd2, 5'd0, 5'd0, 6'd0, 6'd0);
        send_date(1'b1, 14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_date(1'b1, 14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        send_date(1'b0, 14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        send_date(1'b1, 14'd1582, 4'd0, 5'd15, 5'd6, 6'd30, 6'd1);
        send_date(1'b1, 14'd1900, 4'd13, 5'd28, 5'd0, 6'd0, 6'd1);
        send_date(1'b1, 14'd1600, 4'd14, 5'd29, 5'd0, 6'd1, 6'd0);
        send_date(1'b1, 14'd2024, 4'd3, 5'd1, 5'd1, 6'd0, 6'd0);
        send_date(1'b1, 14'd8191, 4'd2, 5'd16, 5'd16, 6'd32, 6'd32);
        send_date(1'b0, 14'd4242, 4'd7, 5'd10, 5'd15, 6'd21, 6'd42);
        send_date(1'b1, 14'd100, 4'd6, 5'd0, 5'd0, 6'd0, 6'd0);
        // hold off until the queue drains
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) send_random();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d transactions, date and datetime modes, year 0 to 16383,",
                 sent);
        $display("months 0 to 15, out-of-range days and time fields");
        if (fail_count == 0)
            $display("PASS civil_datetime_to_ajd_fraction");
        else
            $display("FAIL civil_datetime_to_ajd_fraction");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("FAIL civil_datetime_to_ajd_fraction");
        $finish;
    end
endmodule
